/* sv/swpm_pkg.sv */
// Shared types and constants of the single-wire programming master.
package swpm_pkg;

	// Transaction request carried by one tick
	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	// Function codes on the input channel
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	// Register indexes on the configuration port
	localparam logic REG_QUARTER_TICKS = 1'b0;
	localparam logic REG_WAIT_LIMIT    = 1'b1;

	localparam logic [7:0] QUARTER_TICKS_RST = 8'd4;
	localparam logic [7:0] WAIT_LIMIT_RST    = 8'd16;

	// Segment lengths and high times, in quarters
	localparam logic [2:0] CELL_QUARTERS  = 3'd4;
	localparam logic [2:0] HAND_QUARTERS  = 3'd3;
	localparam logic [2:0] TAKE_QUARTERS  = 3'd3;
	localparam logic [2:0] DELAY_QUARTERS = 3'd2;
	localparam logic [2:0] ZERO_HIGH      = 3'd1;
	localparam logic [2:0] ONE_HIGH       = 3'd3;
	localparam logic [2:0] HAND_HIGH      = 3'd1;

	// Configuration seen by the sequencer
	typedef struct packed {
		logic [7:0] quarter_ticks;
		logic [7:0] wait_limit;
	} cfg_t;

	// Result of advancing the quarter timer by one tick
	typedef struct packed {
		logic [7:0] tc;
		logic [2:0] qc;
		logic       ended;
	} adv_t;

	// Result of one poll of the wire level
	typedef struct packed {
		logic [7:0] wc;
		logic       hit;
		logic       expired;
	} poll_t;

endpackage

/* sv/swpm_front.sv */
// Front end: accepts ticks, classifies the function code and packs queue entries.
module swpm_front import swpm_pkg::*; #(
	parameter int DATA_BITS = 16,
	parameter int CMD_BITS  = 8,
	parameter int ENT_W     = 2 + CMD_BITS + DATA_BITS + 1
) (
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           func,
	input  logic [CMD_BITS-1:0]  command,
	input  logic [DATA_BITS-1:0] write_data,
	input  logic                 line_in,
	input  logic                 q_full,
	output logic                 q_push,
	output logic [ENT_W-1:0]     q_entry
);

	typedef struct packed {
		op_t                  op;
		logic [CMD_BITS-1:0]  cmd;
		logic [DATA_BITS-1:0] data;
		logic                 line;
	} entry_t;

	entry_t ent;

	// Map function codes; any code other than write or read is a plain tick
	always_comb begin
		ent.cmd  = command;
		ent.data = write_data;
		ent.line = line_in;
		unique case (func)
			FUNC_WRITE: ent.op = OP_WRITE;
			FUNC_READ:  ent.op = OP_READ;
			default:    ent.op = OP_TICK;
		endcase
	end

	// Hold the channel while the queue is full
	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;
	assign q_entry  = ent;

endmodule

/* sv/swpm_queue.sv */
// Two-entry queue between the front end and the wire sequencer.
module swpm_queue #(
	parameter int WIDTH = 27
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             pop_valid,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full      = (count_q == 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_data  = mem_q[rd_ptr_q];

	// Store incoming entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

/* sv/swpm_seq.sv */
// Back end: wire sequencer, one tick per queue entry, with registered results.
module swpm_seq import swpm_pkg::*; #(
	parameter int DATA_BITS = 16,
	parameter int CMD_BITS  = 8,
	parameter int ENT_W     = 2 + CMD_BITS + DATA_BITS + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 q_valid,
	input  logic [ENT_W-1:0]     q_entry,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 line_drive,
	output logic                 line_enable,
	output logic                 busy_res,
	output logic                 done_res,
	output logic [DATA_BITS-1:0] read_data,
	output logic                 wait_timeout
);

	localparam int TOTAL_BITS = CMD_BITS + DATA_BITS;
	localparam int BC_W       = $clog2(TOTAL_BITS + 1);
	localparam logic [BC_W-1:0] CMD_LIM   = BC_W'(CMD_BITS);
	localparam logic [BC_W-1:0] TOTAL_LIM = BC_W'(TOTAL_BITS);
	localparam logic [BC_W-1:0] DATA_LIM  = BC_W'(DATA_BITS);

	typedef enum logic [3:0] {
		PH_IDLE  = 4'd0,
		PH_START = 4'd1,
		PH_SEND  = 4'd2,
		PH_STOP  = 4'd3,
		PH_HAND  = 4'd4,
		PH_WAITH = 4'd5,
		PH_DELAY = 4'd6,
		PH_WAITL = 4'd7,
		PH_TAKE  = 4'd8
	} phase_t;

	typedef struct packed {
		op_t                  op;
		logic [CMD_BITS-1:0]  cmd;
		logic [DATA_BITS-1:0] data;
		logic                 line;
	} entry_t;

	// Step the quarter timer through a segment of n quarters
	function automatic adv_t advance(input logic [7:0] tc_i, input logic [2:0] qc_i,
	                                 input logic [2:0] n, input logic [7:0] qt);
		adv_t       r;
		logic [8:0] nxt;
		nxt     = {1'b0, tc_i} + 9'd1;
		r.tc    = nxt[7:0];
		r.qc    = qc_i;
		r.ended = 1'b0;
		if (nxt >= {1'b0, qt}) begin
			r.tc = 8'd0;
			if (qc_i + 3'd1 >= n) begin
				r.qc    = 3'd0;
				r.ended = 1'b1;
			end else begin
				r.qc = qc_i + 3'd1;
			end
		end
		return r;
	endfunction

	// Count one poll of an awaited level
	function automatic poll_t poll(input logic seen, input logic want,
	                               input logic [7:0] wc_i, input logic [7:0] lim);
		poll_t r;
		r.wc      = wc_i;
		r.hit     = 1'b0;
		r.expired = 1'b0;
		if (seen == want) begin
			r.hit = 1'b1;
		end else begin
			r.wc = wc_i + 8'd1;
			if (r.wc >= lim) begin
				r.hit     = 1'b1;
				r.expired = 1'b1;
			end
		end
		return r;
	endfunction

	phase_t                phase_q;
	logic [7:0]            tick_count_q;
	logic [2:0]            quarter_count_q;
	logic [BC_W-1:0]       bit_count_q;
	logic [TOTAL_BITS-1:0] send_shift_q;
	logic [DATA_BITS-1:0]  receive_shift_q;
	logic                  read_mode_q;
	logic                  timeout_flag_q;
	logic [7:0]            wait_count_q;

	logic out_valid_q;
	logic drive_q, enable_q, busy_q, done_q;

	phase_t                ph;
	logic [7:0]            tc;
	logic [2:0]            qc;
	logic [BC_W-1:0]       bc;
	logic [TOTAL_BITS-1:0] ss;
	logic [DATA_BITS-1:0]  rs;
	logic                  rm;
	logic                  tf;
	logic [7:0]            wc;
	logic                  drive, enable, busy, done;
	logic [7:0]            qt, lim;
	logic [2:0]            high;
	logic [BC_W-1:0]       limit;
	adv_t                  a;
	poll_t                 p;
	entry_t                ent;

	assign ent   = q_entry;
	assign qt    = (cfg.quarter_ticks == 8'd0) ? 8'd1 : cfg.quarter_ticks;
	assign lim   = (cfg.wait_limit == 8'd0) ? 8'd1 : cfg.wait_limit;
	assign q_pop = q_valid && (!out_valid_q || !out_stall);

	// Next state and wire levels for the tick at the head of the queue
	always_comb begin
		ph     = phase_q;
		tc     = tick_count_q;
		qc     = quarter_count_q;
		bc     = bit_count_q;
		ss     = send_shift_q;
		rs     = receive_shift_q;
		rm     = read_mode_q;
		tf     = timeout_flag_q;
		wc     = wait_count_q;
		drive  = 1'b1;
		enable = 1'b1;
		done   = 1'b0;
		high   = ZERO_HIGH;
		limit  = TOTAL_LIM;
		a      = '0;
		p      = '0;

		// Start a transaction only from idle
		if (ph == PH_IDLE && ent.op != OP_TICK) begin
			tc = 8'd0;
			qc = 3'd0;
			bc = '0;
			wc = 8'd0;
			if (ent.op == OP_WRITE) begin
				rm = 1'b0;
				ss = {ent.cmd, ent.data};
			end else begin
				rm = 1'b1;
				ss = {ent.cmd | CMD_BITS'(1), DATA_BITS'(0)};
				rs = '0;
				tf = 1'b0;
			end
			ph = PH_START;
		end
		busy = (ph != PH_IDLE);

		unique case (ph)
			PH_IDLE: begin
			end
			PH_START: begin
				drive = 1'b0;
				a = advance(tc, qc, CELL_QUARTERS, qt);
				tc = a.tc;
				qc = a.qc;
				if (a.ended) begin
					ph = PH_SEND;
				end
			end
			PH_SEND: begin
				high  = ss[TOTAL_BITS-1] ? ONE_HIGH : ZERO_HIGH;
				limit = rm ? CMD_LIM : TOTAL_LIM;
				drive = (qc < high);
				a = advance(tc, qc, CELL_QUARTERS, qt);
				tc = a.tc;
				qc = a.qc;
				if (a.ended) begin
					ss = {ss[TOTAL_BITS-2:0], 1'b0};
					bc = bc + BC_W'(1);
					if (bc >= limit) begin
						bc = '0;
						ph = rm ? PH_HAND : PH_STOP;
					end
				end
			end
			PH_HAND: begin
				drive = (qc < HAND_HIGH);
				a = advance(tc, qc, HAND_QUARTERS, qt);
				tc = a.tc;
				qc = a.qc;
				if (a.ended) begin
					wc = 8'd0;
					ph = (bc >= DATA_LIM) ? PH_TAKE : PH_WAITH;
				end
			end
			PH_WAITH: begin
				drive  = 1'b0;
				enable = 1'b0;
				p  = poll(ent.line, 1'b1, wc, lim);
				wc = p.wc;
				if (p.expired) begin
					tf = 1'b1;
				end
				if (p.hit) begin
					tc = 8'd0;
					qc = 3'd0;
					ph = PH_DELAY;
				end
			end
			PH_DELAY: begin
				drive  = 1'b0;
				enable = 1'b0;
				a = advance(tc, qc, DELAY_QUARTERS, qt);
				tc = a.tc;
				qc = a.qc;
				if (a.ended) begin
					rs = {rs[DATA_BITS-2:0], ent.line};
					bc = bc + BC_W'(1);
					wc = 8'd0;
					if (ent.line) begin
						ph = PH_WAITL;
					end else begin
						tc = 8'd0;
						qc = 3'd0;
						ph = (bc >= DATA_LIM) ? PH_TAKE : PH_WAITH;
					end
				end
			end
			PH_WAITL: begin
				drive  = 1'b0;
				enable = 1'b0;
				p  = poll(ent.line, 1'b0, wc, lim);
				wc = p.wc;
				if (p.expired) begin
					tf = 1'b1;
				end
				if (p.hit) begin
					wc = 8'd0;
					tc = 8'd0;
					qc = 3'd0;
					ph = (bc >= DATA_LIM) ? PH_TAKE : PH_WAITH;
				end
			end
			PH_TAKE: begin
				drive = 1'b0;
				a = advance(tc, qc, TAKE_QUARTERS, qt);
				tc = a.tc;
				qc = a.qc;
				if (a.ended) begin
					ph = PH_STOP;
				end
			end
			PH_STOP: begin
				a = advance(tc, qc, CELL_QUARTERS, qt);
				tc = a.tc;
				qc = a.qc;
				if (a.ended) begin
					ph   = PH_IDLE;
					done = 1'b1;
				end
			end
			default: begin
				ph = PH_IDLE;
			end
		endcase
	end

	// Hold sequencer state and the result register; advance on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_IDLE;
			tick_count_q    <= 8'd0;
			quarter_count_q <= 3'd0;
			bit_count_q     <= '0;
			send_shift_q    <= '0;
			receive_shift_q <= '0;
			read_mode_q     <= 1'b0;
			timeout_flag_q  <= 1'b0;
			wait_count_q    <= 8'd0;
			out_valid_q     <= 1'b0;
			drive_q         <= 1'b1;
			enable_q        <= 1'b1;
			busy_q          <= 1'b0;
			done_q          <= 1'b0;
		end else begin
			if (q_pop) begin
				phase_q         <= ph;
				tick_count_q    <= tc;
				quarter_count_q <= qc;
				bit_count_q     <= bc;
				send_shift_q    <= ss;
				receive_shift_q <= rs;
				read_mode_q     <= rm;
				timeout_flag_q  <= tf;
				wait_count_q    <= wc;
				drive_q         <= drive && enable;
				enable_q        <= enable;
				busy_q          <= busy;
				done_q          <= done;
				out_valid_q     <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign line_drive   = drive_q;
	assign line_enable  = enable_q;
	assign busy_res     = busy_q;
	assign done_res     = done_q;
	assign read_data    = receive_shift_q;
	assign wait_timeout = timeout_flag_q;

endmodule

/* sv/pwm_single_wire_prog_master.sv */
// Top level: pulse-width-coded single-wire programming master with APB registers.
// A tick passes through the two-entry queue and then the result register.
// Throughput: one tick per cycle while neither side stalls.
// The two-entry queue and the result register let either side stall alone.
// Reset (arst_n low) returns registers to 4 and 16 and the sequencer to idle,
// with the wire driven high; no clearing pass is needed.
module pwm_single_wire_prog_master import swpm_pkg::*; #(
	parameter int DATA_BITS = 16,
	parameter int CMD_BITS  = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           func,
	input  logic [CMD_BITS-1:0]  command,
	input  logic [DATA_BITS-1:0] write_data,
	input  logic                 line_in,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 line_drive,
	output logic                 line_enable,
	output logic                 busy_res,
	output logic                 done_res,
	output logic [DATA_BITS-1:0] read_data,
	output logic                 wait_timeout
);

	localparam int ENT_W = 2 + CMD_BITS + DATA_BITS + 1;

	cfg_t             cfg_q;
	logic             q_full;
	logic             q_push;
	logic             q_pop;
	logic             q_valid;
	logic [ENT_W-1:0] push_entry;
	logic [ENT_W-1:0] pop_entry;

	// Write configuration registers on the APB access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.quarter_ticks <= QUARTER_TICKS_RST;
			cfg_q.wait_limit    <= WAIT_LIMIT_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_QUARTER_TICKS: cfg_q.quarter_ticks <= pwdata[7:0];
				REG_WAIT_LIMIT:    cfg_q.wait_limit    <= pwdata[7:0];
				default:           cfg_q.wait_limit    <= pwdata[7:0];
			endcase
		end
	end

	// Return register contents on reads
	always_comb begin
		unique case (paddr[2])
			REG_QUARTER_TICKS: prdata = {24'd0, cfg_q.quarter_ticks};
			REG_WAIT_LIMIT:    prdata = {24'd0, cfg_q.wait_limit};
			default:           prdata = 32'd0;
		endcase
	end

	assign pready = 1'b1;

	swpm_front #(
		.DATA_BITS (DATA_BITS),
		.CMD_BITS  (CMD_BITS),
		.ENT_W     (ENT_W)
	) u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.command    (command),
		.write_data (write_data),
		.line_in    (line_in),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_entry    (push_entry)
	);

	swpm_queue #(
		.WIDTH (ENT_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_entry),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_data  (pop_entry)
	);

	swpm_seq #(
		.DATA_BITS (DATA_BITS),
		.CMD_BITS  (CMD_BITS),
		.ENT_W     (ENT_W)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (q_valid),
		.q_entry      (pop_entry),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.line_drive   (line_drive),
		.line_enable  (line_enable),
		.busy_res     (busy_res),
		.done_res     (done_res),
		.read_data    (read_data),
		.wait_timeout (wait_timeout)
	);

	// A finishing tick is always part of a transaction
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> busy_res)
		else $error("done without busy");

	// A released wire is never driven high and occurs only within a transaction
	a_release_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !line_enable |-> !line_drive && busy_res)
		else $error("released wire driven or idle");

	// An idle tick drives the wire high and never finishes a transaction
	a_idle_high: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !busy_res |-> line_enable && line_drive && !done_res)
		else $error("idle line not high");

	// The queue never takes a transfer while it is full, and the input channel is then stalled
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_push && in_stall)
		else $error("push into full queue");

endmodule
